FILE: rtl/grs_pkg.sv
// ----------------------------------------------------------------------------
// grs_pkg - shared types for the greedy ratio selection block
// Entry layout, command kinds, cell operations and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package grs_pkg;

    typedef struct packed {
        logic [15:0] nmask;
        logic [15:0] prof;
        logic [15:0] dur;
        logic [3:0]  id;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 56;
    localparam int SEL_CNT_W = 5;
    localparam int TOTAL_W = 20;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [SEL_CNT_W-1:0] SEL_CNT_MAX = '1;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_SOLVE = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_CMP,
        OP_INS,
        OP_ROT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        entry_t   item;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_INS,
        ST_WALK,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/grs_cell.sv
// ----------------------------------------------------------------------------
// grs_cell - one slot of the sorted item chain
// Holds one entry and its chosen flag, compares its ratio against a new
// item, and shifts or rotates entries to and from its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module grs_cell
    import grs_pkg::*;
(
    input  wire        aclk,
    input  cell_ctrl_t ctrl,
    input  wire        occupied,
    input  entry_t     prev_entry,
    input  wire        prev_flag,
    input  wire        shift_above,
    input  wire        shift_below,
    output entry_t     entry_o,
    output logic       flag_o,
    output logic       shift_o
);

    entry_t      entry_reg;
    logic        flag_reg;
    logic        gt_reg;
    logic [31:0] lhs;
    logic [31:0] rhs;

    assign lhs = 32'(entry_reg.prof) * 32'(ctrl.item.dur);
    assign rhs = 32'(ctrl.item.prof) * 32'(entry_reg.dur);

    assign shift_o = (!occupied || gt_reg) && shift_above;
    assign entry_o = entry_reg;
    assign flag_o  = flag_reg;

    always_ff @(posedge aclk) begin
        case (ctrl.op)
            OP_CMP: begin
                gt_reg <= lhs > rhs;
            end
            OP_INS: begin
                if (shift_below) begin
                    entry_reg <= prev_entry;
                end else if (shift_o) begin
                    entry_reg <= ctrl.item;
                end
            end
            OP_ROT: begin
                entry_reg <= prev_entry;
                flag_reg  <= prev_flag;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/greedy_ratio_selection_with_conflicts.sv
// ----------------------------------------------------------------------------
// greedy_ratio_selection_with_conflicts - greedy selection by profit density
// Sorted chain of item cells with a walk controller and an output register.
// ----------------------------------------------------------------------------
// A load (s_tuser = load) is handled in order: the word is captured, every
// cell compares its stored ratio against the new one with its own pair of
// 16x16 multipliers, then the chain opens a slot and inserts; a load into a
// full store is dropped when it is captured. A solve captures the word,
// rotates the whole chain once past the selection logic, then rotates it
// again to present the chosen ids, holding the rotation whenever a chosen
// id waits for the output register to free up; an empty selection instead
// gives a single word once the walk is done and the output register is
// free. Clear and unused kinds are done as soon as they are captured. The
// next input word is taken once the block is back in idle; a last result
// may still sit in the output register then.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_ratio_selection_with_conflicts
    import grs_pkg::*;
#(
    parameter int MAX_ITEMS = 16
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     cfg_valid,
    output logic                    cfg_ready,
    input  wire  [TOTAL_W-1:0]      cfg_data,      // time_budget
    input  wire                     s_tvalid,
    output logic                    s_tready,
    input  wire  [S_DATA_W-1:0]     s_tdata,       // item_id, duration, profit, neighbor_mask
    input  wire  [1:0]              s_tuser,       // kind
    output logic                    m_tvalid,
    input  wire                     m_tready,
    output logic [M_DATA_W-1:0]     m_tdata,       // chosen_id, selected_count, total_profit,
                                                   // total_time
    output logic                    m_tuser,       // has_id
    output logic                    m_tlast
);

    localparam int IDX_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int GAIN_W = 16 + IDX_W;
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_ITEMS - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_ITEMS);

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [15:0]          taken_reg, taken_next;
    logic [TOTAL_W-1:0]   budget_reg;
    logic [TOTAL_W-1:0]   used_reg, used_next;
    logic [GAIN_W-1:0]    gain_reg, gain_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic [CNT_W-1:0]     emit_reg, emit_next;
    logic [IDX_W-1:0]     step_reg, step_next;
    entry_t               item_reg, item_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [3:0]           out_id_reg, out_id_next;
    logic                 out_has_reg, out_has_next;
    logic [SEL_CNT_W-1:0] out_cnt_reg, out_cnt_next;
    logic [TOTAL_W-1:0]   out_gain_reg, out_gain_next;
    logic [TOTAL_W-1:0]   out_time_reg, out_time_next;
    logic                 out_last_reg, out_last_next;

    cell_ctrl_t           cell_ctrl;
    entry_t               cell_entry [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] cell_flag;
    logic [MAX_ITEMS-1:0] cell_shift;
    logic [MAX_ITEMS-1:0] shift_hi;
    logic [MAX_ITEMS-1:0] shift_lo;
    logic                 rot_flag;

    kind_t                in_kind;
    logic                 in_accept;
    entry_t               top;
    logic [IDX_W-1:0]     top_index;
    logic                 top_valid;
    logic [TOTAL_W:0]     used_sum;
    logic                 fits;
    logic                 compat;
    logic                 take;
    logic                 out_free;
    logic                 top_chosen;
    logic                 advance;
    logic                 out_load;
    logic [CNT_W+SEL_CNT_W-1:0] k_ext;
    logic [GAIN_W+TOTAL_W-1:0]  gain_ext;
    logic [SEL_CNT_W-1:0] sat_cnt;
    logic [TOTAL_W-1:0]   sat_gain;

    assign in_kind   = kind_t'(s_tuser);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign shift_hi = {1'b1, cell_shift[MAX_ITEMS-1:1]};
    assign shift_lo = {cell_shift[MAX_ITEMS-2:0], 1'b0};

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
            entry_t prev_e;
            logic   prev_f;
            if (gi == 0) begin : g_head
                assign prev_e = cell_entry[MAX_ITEMS-1];
                assign prev_f = rot_flag;
            end else begin : g_body
                assign prev_e = cell_entry[gi-1];
                assign prev_f = cell_flag[gi-1];
            end
            grs_cell u_cell (
                .aclk        (aclk),
                .ctrl        (cell_ctrl),
                .occupied    (CNT_W'(gi) < count_reg),
                .prev_entry  (prev_e),
                .prev_flag   (prev_f),
                .shift_above (shift_hi[gi]),
                .shift_below (shift_lo[gi]),
                .entry_o     (cell_entry[gi]),
                .flag_o      (cell_flag[gi]),
                .shift_o     (cell_shift[gi])
            );
        end
    endgenerate

    assign top        = cell_entry[MAX_ITEMS-1];
    assign top_chosen = cell_flag[MAX_ITEMS-1];
    assign top_index  = LAST_STEP - step_reg;
    assign top_valid  = CNT_W'(top_index) < count_reg;
    assign used_sum   = {1'b0, used_reg} + {{(TOTAL_W-16+1){1'b0}}, top.dur};
    assign fits       = used_sum <= {1'b0, budget_reg};
    assign compat     = (top.nmask & taken_reg) == taken_reg;
    assign take       = top_valid && fits && compat;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign advance    = !top_chosen || out_free;

    assign k_ext    = {{SEL_CNT_W{1'b0}}, k_reg};
    assign gain_ext = {{TOTAL_W{1'b0}}, gain_reg};
    assign sat_cnt  = (k_ext > (CNT_W+SEL_CNT_W)'(SEL_CNT_MAX)) ?
                      SEL_CNT_MAX : k_ext[SEL_CNT_W-1:0];
    assign sat_gain = (gain_ext > (GAIN_W+TOTAL_W)'(TOTAL_MAX)) ?
                      TOTAL_MAX : gain_ext[TOTAL_W-1:0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (in_kind)
                        KIND_LOAD: begin
                            if (count_reg < FULL) begin
                                state_next = ST_CMP;
                            end
                        end
                        KIND_SOLVE: begin
                            state_next = ST_WALK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CMP: begin
                state_next = ST_INS;
            end
            ST_INS: begin
                state_next = ST_IDLE;
            end
            ST_WALK: begin
                if (step_reg == LAST_STEP) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (k_reg == '0) begin
                    if (out_free) begin
                        state_next = ST_IDLE;
                    end
                end else if (advance && step_reg == LAST_STEP) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready       = 1'b0;
        cell_ctrl.op   = OP_HOLD;
        cell_ctrl.item = item_reg;
        rot_flag       = top_chosen;
        out_load       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_CMP: begin
                cell_ctrl.op = OP_CMP;
            end
            ST_INS: begin
                cell_ctrl.op = OP_INS;
            end
            ST_WALK: begin
                cell_ctrl.op = OP_ROT;
                rot_flag     = take;
            end
            ST_EMIT: begin
                if (k_reg == '0) begin
                    out_load = out_free;
                end else begin
                    out_load = out_free && top_chosen;
                    if (advance) begin
                        cell_ctrl.op = OP_ROT;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        count_next    = count_reg;
        taken_next    = taken_reg;
        used_next     = used_reg;
        gain_next     = gain_reg;
        k_next        = k_reg;
        emit_next     = emit_reg;
        step_next     = step_reg;
        item_next     = item_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_id_next   = out_id_reg;
        out_has_next  = out_has_reg;
        out_cnt_next  = out_cnt_reg;
        out_gain_next = out_gain_reg;
        out_time_next = out_time_reg;
        out_last_next = out_last_reg;

        if (in_accept) begin
            item_next = entry_t'(s_tdata[ENTRY_W-1:0]);
            case (in_kind)
                KIND_SOLVE: begin
                    taken_next = '0;
                    used_next  = '0;
                    gain_next  = '0;
                    k_next     = '0;
                    emit_next  = '0;
                    step_next  = '0;
                end
                KIND_CLEAR: begin
                    count_next = '0;
                    taken_next = '0;
                end
                default: begin
                end
            endcase
        end

        if (state_reg == ST_INS) begin
            count_next = count_reg + 1'b1;
        end

        if (state_reg == ST_WALK) begin
            step_next = (step_reg == LAST_STEP) ? '0 : step_reg + 1'b1;
            if (take) begin
                taken_next = taken_reg | (16'b1 << top.id);
                used_next  = used_sum[TOTAL_W-1:0];
                gain_next  = gain_reg + GAIN_W'(top.prof);
                k_next     = k_reg + 1'b1;
            end
        end

        if (state_reg == ST_EMIT && k_reg != '0 && advance) begin
            step_next = (step_reg == LAST_STEP) ? '0 : step_reg + 1'b1;
        end

        if (out_load) begin
            m_tvalid_next = 1'b1;
            if (k_reg == '0) begin
                out_id_next   = '0;
                out_has_next  = 1'b0;
                out_cnt_next  = '0;
                out_gain_next = '0;
                out_time_next = '0;
                out_last_next = 1'b1;
            end else begin
                out_id_next   = top.id;
                out_has_next  = 1'b1;
                out_cnt_next  = sat_cnt;
                out_gain_next = sat_gain;
                out_time_next = used_reg;
                out_last_next = (emit_reg + 1'b1) == k_reg;
                emit_next     = emit_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            taken_reg    <= '0;
            budget_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            taken_reg    <= taken_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                budget_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        used_reg     <= used_next;
        gain_reg     <= gain_next;
        k_reg        <= k_next;
        emit_reg     <= emit_next;
        step_reg     <= step_next;
        item_reg     <= item_next;
        out_id_reg   <= out_id_next;
        out_has_reg  <= out_has_next;
        out_cnt_reg  <= out_cnt_next;
        out_gain_reg <= out_gain_next;
        out_time_reg <= out_time_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_has_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_DATA_W-4-SEL_CNT_W-2*TOTAL_W){1'b0}},
                       out_time_reg, out_gain_reg, out_cnt_reg, out_id_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL)
        else $error("item count beyond capacity");

    a_budget_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> used_reg <= budget_reg)
        else $error("selected time exceeds budget");

    a_pick_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> k_reg <= count_reg)
        else $error("more picks than stored items");

    a_emit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> emit_reg <= k_reg)
        else $error("more words emitted than picks");

endmodule

`default_nettype wire

FILE: sim/grs_selection_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grs_selection_checker - selection predictor and scoreboard
// Watches the budget, input and result channels of the greedy ratio selection
// block. Keeps its own ratio-sorted store of loaded items, works out the
// selection of every accepted solve and compares each result word, field by
// field, with the oldest pending one.
// ----------------------------------------------------------------------------

module grs_selection_checker
    import grs_pkg::*;
#(
    parameter int MAX_ITEMS = 16
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     cfg_valid,
    input  wire                     cfg_ready,
    input  wire  [TOTAL_W-1:0]      cfg_data,
    input  wire                     s_tvalid,
    input  wire                     s_tready,
    input  wire  [S_DATA_W-1:0]     s_tdata,
    input  wire  [1:0]              s_tuser,
    input  wire                     m_tvalid,
    input  wire                     m_tready,
    input  wire  [M_DATA_W-1:0]     m_tdata,
    input  wire                     m_tuser,
    input  wire                     m_tlast,
    output int                      mismatches,
    output int                      pending,
    output int                      words_checked
);

    typedef struct {
        logic [3:0]           id;
        logic                 has_id;
        logic [SEL_CNT_W-1:0] count;
        logic [TOTAL_W-1:0]   profit;
        logic [TOTAL_W-1:0]   span;
        logic                 last;
    } pick_t;

    entry_t             ranked [MAX_ITEMS];
    int                 stored;
    logic [TOTAL_W-1:0] budget;
    pick_t              picks_q[$];

    initial begin
        mismatches    = 0;
        pending       = 0;
        words_checked = 0;
    end

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        if (mismatches < 40) begin
            $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        end
        mismatches++;
    endtask

    // strict density order by cross-multiplication
    function automatic logic denser(entry_t a, entry_t b);
        logic [31:0] lhs;
        logic [31:0] rhs;
        lhs = 32'(a.prof) * 32'(b.dur);
        rhs = 32'(b.prof) * 32'(a.dur);
        return lhs > rhs;
    endfunction

    task automatic insert_item(entry_t e);
        int pos;
        if (stored >= MAX_ITEMS) begin
            return;
        end
        pos = stored;
        while (pos > 0 && denser(ranked[pos-1], e)) begin
            ranked[pos] = ranked[pos-1];
            pos--;
        end
        ranked[pos] = e;
        stored++;
    endtask

    task automatic predict_selection();
        entry_t     e;
        logic [15:0] taken;
        logic [20:0] used;
        logic [24:0] gain;
        logic [3:0]  ids[$];
        pick_t       p;
        taken = '0;
        used  = '0;
        gain  = '0;
        for (int i = stored - 1; i >= 0; i--) begin
            e = ranked[i];
            if (used + 21'(e.dur) <= 21'(budget) && (e.nmask & taken) == taken) begin
                ids.push_back(e.id);
                taken |= 16'd1 << e.id;
                used  += 21'(e.dur);
                gain  += 25'(e.prof);
            end
        end
        p.profit = (gain > 25'(TOTAL_MAX)) ? TOTAL_MAX : gain[TOTAL_W-1:0];
        p.span   = used[TOTAL_W-1:0];
        p.count  = (ids.size() > int'(SEL_CNT_MAX)) ? SEL_CNT_MAX : SEL_CNT_W'(ids.size());
        if (ids.size() == 0) begin
            p.id     = '0;
            p.has_id = 1'b0;
            p.last   = 1'b1;
            picks_q.push_back(p);
        end else begin
            foreach (ids[k]) begin
                p.id     = ids[k];
                p.has_id = 1'b1;
                p.last   = (k == ids.size() - 1);
                picks_q.push_back(p);
            end
        end
    endtask

    task automatic check_word();
        pick_t want;
        if (picks_q.size() == 0) begin
            report("word with no selection pending, chosen_id", 32'(m_tdata[3:0]), 0);
            return;
        end
        want = picks_q.pop_front();
        words_checked++;
        if (m_tdata[3:0] !== want.id) begin
            report("chosen_id", 32'(m_tdata[3:0]), 32'(want.id));
        end
        if (m_tuser !== want.has_id) begin
            report("has_id", 32'(m_tuser), 32'(want.has_id));
        end
        if (m_tdata[8:4] !== want.count) begin
            report("selected_count", 32'(m_tdata[8:4]), 32'(want.count));
        end
        if (m_tdata[28:9] !== want.profit) begin
            report("total_profit", 32'(m_tdata[28:9]), 32'(want.profit));
        end
        if (m_tdata[48:29] !== want.span) begin
            report("total_time", 32'(m_tdata[48:29]), 32'(want.span));
        end
        if (m_tlast !== want.last) begin
            report("last", 32'(m_tlast), 32'(want.last));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            stored = 0;
            budget = '0;
            picks_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                budget = cfg_data;
            end
            if (m_tvalid && m_tready) begin
                check_word();
            end
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    KIND_LOAD:  insert_item(entry_t'(s_tdata[ENTRY_W-1:0]));
                    KIND_SOLVE: predict_selection();
                    KIND_CLEAR: stored = 0;
                    default:    ;
                endcase
            end
        end
        pending = picks_q.size();
    end

endmodule

FILE: sim/greedy_ratio_selection_with_conflicts_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_ratio_selection_with_conflicts_test - stimulus and verdict
// Drives budgets, item loads, solves and clears into the selection block with
// random gaps on the input side and random stalls on the result side. A
// directed opening covers empty stores, extreme fields, zero durations and
// repeated ids; random phases then build stores of varied size up to and past
// full. The checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------

module greedy_ratio_selection_with_conflicts_test;
    import grs_pkg::*;

    localparam int         N            = 16;
    localparam int         HALF_PERIOD  = 10;
    localparam int         RESET_CYCLES = 11;
    localparam int         GAP_MAX      = 6;
    localparam int         SETTLE       = 3 * N + 10;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         ITEM_TARGET  = 160;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [TOTAL_W-1:0]  cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic [1:0]          s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    int   mismatches;
    int   pending;
    int   words_checked;

    bit   steady       = 1'b0;
    bit   m_took       = 1'b0;
    int   stall_left   = 0;
    int   quiet_cycles = 0;
    int   counted      = 0;
    int   held         = 0;
    int   loads_sent   = 0;
    int   loads_full   = 0;
    int   solves_sent  = 0;
    int   budgets_set  = 0;

    always #(HALF_PERIOD) aclk = ~aclk;

    greedy_ratio_selection_with_conflicts uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    grs_selection_checker #(.MAX_ITEMS(N)) selection_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .mismatches    (mismatches),
        .pending       (pending),
        .words_checked (words_checked)
    );

    // draw a fresh stall after every accepted result word
    always @(posedge aclk) begin
        m_took <= m_tvalid && m_tready;
    end

    always @(negedge aclk) begin
        if (m_took) begin
            stall_left = steady ? 0 : $urandom_range(0, GAP_MAX);
        end
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d words pending",
                     quiet_cycles, pending);
            $display("greedy_ratio_selection_with_conflicts test failed");
            $finish;
        end
    end

    function automatic entry_t make_item(logic [3:0] id, logic [15:0] dur, logic [15:0] prof,
                                         logic [15:0] nmask);
        entry_t e;
        e.id    = id;
        e.dur   = dur;
        e.prof  = prof;
        e.nmask = nmask;
        return e;
    endfunction

    function automatic entry_t random_item();
        entry_t e;
        e.id = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 7))
            0:       e.dur = '0;
            1, 2:    e.dur = 16'($urandom);
            default: e.dur = 16'($urandom_range(1, 3000));
        endcase
        case ($urandom_range(0, 7))
            0:       e.prof = '0;
            1:       e.prof = 16'($urandom_range(0, 255));
            default: e.prof = 16'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0:       e.nmask = 16'hFFFF;
            1:       e.nmask = 16'($urandom);
            2:       e.nmask = ~(16'd1 << $urandom_range(0, 15));
            default: e.nmask = 16'($urandom | $urandom | $urandom);
        endcase
        return e;
    endfunction

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(logic [1:0] kind, entry_t e);
        int gap;
        gap = steady ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(S_DATA_W - ENTRY_W){1'b0}}, e};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        case (kind)
            KIND_LOAD: begin
                loads_sent++;
                if (held < N) begin
                    held++;
                end else begin
                    loads_full++;
                end
            end
            KIND_SOLVE: begin
                solves_sent++;
            end
            KIND_CLEAR: begin
                held = 0;
            end
            default: ;
        endcase
        counted++;
    endtask

    // drop valid, wait for every pending word and let the block fall idle
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_budget(logic [TOTAL_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        budgets_set++;
    endtask

    initial begin
        int n;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_budget(TOTAL_MAX);
        send_word(KIND_UNUSED, random_item());
        send_word(KIND_SOLVE, random_item());
        send_word(KIND_LOAD, make_item(4'd0, 16'd0, 16'd0, 16'h0000));
        send_word(KIND_LOAD, make_item(4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_word(KIND_LOAD, make_item(4'd7, 16'd0, 16'd5, 16'hFFFF));
        send_word(KIND_LOAD, make_item(4'd15, 16'd1, 16'd1, 16'h7FFF));
        send_word(KIND_LOAD, make_item(4'd3, 16'd100, 16'd300, 16'h8081));
        send_word(KIND_SOLVE, random_item());
        send_word(KIND_CLEAR, random_item());
        send_word(KIND_SOLVE, random_item());
        settle();
        set_budget('0);
        send_word(KIND_LOAD, make_item(4'd1, 16'd0, 16'd10, 16'hFFFF));
        send_word(KIND_LOAD, make_item(4'd2, 16'd1, 16'd1, 16'hFFFF));
        send_word(KIND_LOAD, make_item(4'd4, 16'd0, 16'hFFFF, 16'h0006));
        send_word(KIND_SOLVE, random_item());
        send_word(KIND_CLEAR, random_item());
        send_word(KIND_SOLVE, random_item());

        while (counted < ITEM_TARGET) begin
            if ($urandom_range(0, 1) == 0) begin
                settle();
                case ($urandom_range(0, 5))
                    0:       set_budget('0);
                    1:       set_budget(TOTAL_MAX);
                    2:       set_budget(TOTAL_W'($urandom_range(0, int'(TOTAL_MAX))));
                    default: set_budget(TOTAL_W'($urandom_range(2000, 40000)));
                endcase
            end
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0) begin
                send_word(KIND_CLEAR, random_item());
            end
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 10);
            repeat (n) begin
                if ($urandom_range(0, 11) == 0) begin
                    send_word(KIND_UNUSED, random_item());
                end
                send_word(KIND_LOAD, random_item());
            end
            send_word(KIND_SOLVE, random_item());
            if ($urandom_range(0, 4) == 0) begin
                send_word(KIND_SOLVE, random_item());
            end
        end

        steady = 1'b0;
        settle();

        $display("covered %0d loads (%0d into a full store), %0d solves, %0d budget settings",
                 loads_sent, loads_full, solves_sent, budgets_set);
        $display("checked %0d selection words, %0d mismatches", words_checked, mismatches);
        if (mismatches == 0) begin
            $display("greedy_ratio_selection_with_conflicts test passed");
        end else begin
            $display("greedy_ratio_selection_with_conflicts test failed");
        end
        $finish;
    end

endmodule

FILE: greedy_ratio_selection_with_conflicts.f
rtl/grs_pkg.sv
rtl/grs_cell.sv
rtl/greedy_ratio_selection_with_conflicts.sv
sim/grs_selection_checker.sv
sim/greedy_ratio_selection_with_conflicts_test.sv
